// ----- rtl/rgb_led_chain_serializer_core_defines.svh -----
// Assertion macros shared by the serializer RTL.
`ifndef RGB_LED_CHAIN_SERIALIZER_CORE_DEFINES_SVH
`define RGB_LED_CHAIN_SERIALIZER_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define RLCS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rlcs assertion failed");

// Next-cycle implication, disabled during reset.
`define RLCS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rlcs assertion failed");

`endif

// ----- rtl/rlcs_pkg.sv -----
`timescale 1ns / 1ps

package rlcs_pkg;

   // Sizes and constants of the LED chain format
   localparam int NUM_LEDS_DEFAULT = 64;
   localparam int COLOR_BITS       = 24;
   localparam int WAIT_MULT        = 45;
   localparam int THIRD_DIV        = 3;
   localparam int IDX_W            = 10;
   localparam int PERIOD_W         = 10;
   localparam int TICK_W           = 16;
   localparam int THIRD_W          = 9;
   localparam int HIGH_W           = 10;
   localparam int BITSEL_W         = 5;

   // Reciprocal of 3 for a 10-bit value: floor(x / 3) = (x * 683) >> 11
   localparam int THIRD_RECIP      = 683;
   localparam int THIRD_SHIFT      = 11;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(89);
   localparam logic [BITSEL_W-1:0] TOP_BIT      = BITSEL_W'(COLOR_BITS - 1);

   // Op codes
   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_SET   = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;

   // Line phase
   typedef enum logic [1:0] {
      PH_WAIT = 2'd0,
      PH_IDLE = 2'd1,
      PH_SEND = 2'd2
   } phase_type;

   // Item sequencer
   typedef enum logic [1:0] {
      CT_CLEAR,
      CT_READY,
      CT_EXEC
   } ctrl_type;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] pixel_index;
      logic [7:0]       red;
      logic [7:0]       green;
      logic [7:0]       blue;
   } rlcs_req_type;

   typedef struct packed {
      logic line_level;
      logic ready_res;
      logic refused;
   } rlcs_rsp_type;

endpackage

// ----- rtl/rgb_led_chain_serializer_core.sv -----
`timescale 1ns / 1ps
// One-wire LED chain serializer.
// req channel (valid/ready) carries one item: tick, set pixel or start frame.
// rsp channel (valid/ready) returns one result per item: line level, ready flag
// and a refused flag for an index past the end or a start while busy.
// csr_wr_en / csr_wr_data write the bit period; write only while no item is
// in flight.
// Each item has an accept cycle, in which the pixel under the current bit is
// read from the synchronous pixel memory, and an execute cycle,
// in which the state is updated, a set item is written back and the result is
// loaded into the output register. A set item that hits the pixel being read
// is forwarded. A new item is not taken until the current one has executed,
// as set by this single memory read-modify-write.
// After reset a clearing pass writes zero to every pixel, during which
// req_ready stays low; the line then runs its low reset wait on tick items
// before it reports ready.
// When the receiver stalls, the result stays in the output register and the
// next item is held in its execute cycle until the output register drains.
`include "rgb_led_chain_serializer_core_defines.svh"

module rgb_led_chain_serializer_core #(
   parameter int NUM_LEDS = rlcs_pkg::NUM_LEDS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  rlcs_pkg::rlcs_req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rlcs_pkg::rlcs_rsp_type rsp_data,
   input  logic                  csr_wr_en,
   input  logic [rlcs_pkg::PERIOD_W-1:0] csr_wr_data
);

   localparam int PIX_W    = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;
   localparam int DATA_END = NUM_LEDS * rlcs_pkg::COLOR_BITS;
   localparam int SLOTS    = DATA_END + 3;
   localparam int BP_W     = $clog2(SLOTS);
   localparam logic [PIX_W-1:0]             LAST_PIX   = PIX_W'(NUM_LEDS - 1);
   localparam logic [BP_W:0]                SLOTS_L    = (BP_W + 1)'(SLOTS);
   localparam logic [BP_W-1:0]              DATA_END_L = BP_W'(DATA_END);
   localparam logic [rlcs_pkg::IDX_W:0]     NUM_LEDS_L = (rlcs_pkg::IDX_W + 1)'(NUM_LEDS);

   // Registers
   rlcs_pkg::ctrl_type              ctrl_ff, ctrl_in;
   rlcs_pkg::phase_type             phase_ff, phase_in;
   logic [rlcs_pkg::TICK_W-1:0]     tick_ff, tick_in;
   logic [BP_W-1:0]                 bp_ff, bp_in;
   logic [PIX_W-1:0]                pix_ff, pix_in;
   logic [rlcs_pkg::BITSEL_W-1:0]   bit_ff, bit_in;
   logic [PIX_W-1:0]                clr_ff, clr_in;
   rlcs_pkg::rlcs_req_type          item_ff;
   logic                            rsp_valid_ff, rsp_valid_in;
   rlcs_pkg::rlcs_rsp_type          rsp_data_ff, rsp_data_in;
   logic [rlcs_pkg::PERIOD_W-1:0]   period_ff;
   logic [rlcs_pkg::THIRD_W-1:0]    third_ff;
   logic [rlcs_pkg::TICK_W-1:0]     wait_top_ff;
   logic [rlcs_pkg::COLOR_BITS-1:0] rdata_ff;

   // Pixel memory
   logic [rlcs_pkg::COLOR_BITS-1:0] pixel_mem [NUM_LEDS];
   logic                            mem_we;
   logic [PIX_W-1:0]                mem_waddr;
   logic [rlcs_pkg::COLOR_BITS-1:0] mem_wdata;

   // Execute-cycle helpers
   logic                            do_accept;
   logic                            out_free;
   logic                            idx_ok;
   logic [rlcs_pkg::COLOR_BITS-1:0] new_pixel;
   logic [rlcs_pkg::COLOR_BITS-1:0] pixel_now;
   logic [rlcs_pkg::HIGH_W-1:0]     high_ticks;
   logic                            level_now;
   logic [BP_W:0]                   bp_inc;
   logic [rlcs_pkg::TICK_W:0]       tick_inc;
   logic [rlcs_pkg::PERIOD_W+rlcs_pkg::PERIOD_W-1:0] third_prod;

   assign req_ready = (ctrl_ff == rlcs_pkg::CT_READY);
   assign do_accept = req_valid && req_ready;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Memory: one write port, one registered read of the pixel under the bit
   always_ff @(posedge clock) begin
      if (mem_we) begin
         pixel_mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= pixel_mem[pix_ff];
   end

   // Item capture
   always_ff @(posedge clock) begin
      if (do_accept) begin
         item_ff <= req_data;
      end
   end

   // Configuration; divide by 3 and wait length are worked out at write time
   assign third_prod = (rlcs_pkg::PERIOD_W + rlcs_pkg::PERIOD_W)'(csr_wr_data)
                       * (rlcs_pkg::PERIOD_W + rlcs_pkg::PERIOD_W)'(rlcs_pkg::THIRD_RECIP);

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff   <= rlcs_pkg::PERIOD_RESET;
         third_ff    <= rlcs_pkg::THIRD_W'(rlcs_pkg::PERIOD_RESET / rlcs_pkg::THIRD_DIV);
         wait_top_ff <= rlcs_pkg::TICK_W'(rlcs_pkg::PERIOD_RESET * rlcs_pkg::WAIT_MULT + 1);
      end else if (csr_wr_en) begin
         period_ff   <= csr_wr_data;
         third_ff    <= rlcs_pkg::THIRD_W'(third_prod >> rlcs_pkg::THIRD_SHIFT);
         wait_top_ff <= rlcs_pkg::TICK_W'(csr_wr_data)
                        * rlcs_pkg::TICK_W'(rlcs_pkg::WAIT_MULT)
                        + rlcs_pkg::TICK_W'(1);
      end
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff      <= rlcs_pkg::CT_CLEAR;
         phase_ff     <= rlcs_pkg::PH_WAIT;
         tick_ff      <= '0;
         bp_ff        <= '0;
         pix_ff       <= '0;
         bit_ff       <= rlcs_pkg::TOP_BIT;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ctrl_ff      <= ctrl_in;
         phase_ff     <= phase_in;
         tick_ff      <= tick_in;
         bp_ff        <= bp_in;
         pix_ff       <= pix_in;
         bit_ff       <= bit_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Pixel value seen by this item, with forwarding of its own write
   assign idx_ok    = ({1'b0, item_ff.pixel_index} < NUM_LEDS_L);
   assign new_pixel = {item_ff.green, item_ff.red, item_ff.blue};
   assign pixel_now = (item_ff.op == rlcs_pkg::OP_SET && idx_ok
                       && item_ff.pixel_index[PIX_W-1:0] == pix_ff) ? new_pixel : rdata_ff;

   // Line level of the current slot and tick
   assign high_ticks = pixel_now[bit_ff] ? {third_ff, 1'b0}
                                         : {1'b0, third_ff};
   assign level_now  = (phase_ff == rlcs_pkg::PH_SEND) && (bp_ff != '0)
                       && (bp_ff <= DATA_END_L)
                       && (tick_ff < rlcs_pkg::TICK_W'(high_ticks));

   assign bp_inc   = {1'b0, bp_ff} + (BP_W + 1)'(1);
   assign tick_inc = {1'b0, tick_ff} + (rlcs_pkg::TICK_W + 1)'(1);

   // Sequencer, line timing and result
   always_comb begin
      ctrl_in      = ctrl_ff;
      phase_in     = phase_ff;
      tick_in      = tick_ff;
      bp_in        = bp_ff;
      pix_in       = pix_ff;
      bit_in       = bit_ff;
      clr_in       = clr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = clr_ff;
      mem_wdata    = '0;

      unique case (ctrl_ff)
         rlcs_pkg::CT_CLEAR: begin
            mem_we = 1'b1;
            clr_in = clr_ff + PIX_W'(1);
            if (clr_ff == LAST_PIX) begin
               clr_in  = '0;
               ctrl_in = rlcs_pkg::CT_READY;
            end
         end
         rlcs_pkg::CT_READY: begin
            if (do_accept) begin
               ctrl_in = rlcs_pkg::CT_EXEC;
            end
         end
         rlcs_pkg::CT_EXEC: begin
            if (out_free) begin
               ctrl_in               = rlcs_pkg::CT_READY;
               rsp_valid_in          = 1'b1;
               rsp_data_in.line_level = level_now;
               rsp_data_in.refused   = 1'b0;
               unique case (item_ff.op)
                  rlcs_pkg::OP_TICK: begin
                     if (phase_ff == rlcs_pkg::PH_SEND) begin
                        if (tick_ff >= rlcs_pkg::TICK_W'(period_ff)) begin
                           tick_in = '0;
                           bp_in   = bp_inc[BP_W-1:0];
                           if (bp_ff == '0) begin
                              pix_in = '0;
                              bit_in = rlcs_pkg::TOP_BIT;
                           end else if (bit_ff == '0) begin
                              bit_in = rlcs_pkg::TOP_BIT;
                              if (pix_ff != LAST_PIX) begin
                                 pix_in = pix_ff + PIX_W'(1);
                              end
                           end else begin
                              bit_in = bit_ff - rlcs_pkg::BITSEL_W'(1);
                           end
                           if (bp_inc >= SLOTS_L) begin
                              bp_in    = '0;
                              phase_in = rlcs_pkg::PH_WAIT;
                           end
                        end else begin
                           tick_in = tick_inc[rlcs_pkg::TICK_W-1:0];
                        end
                     end else if (phase_ff == rlcs_pkg::PH_WAIT) begin
                        tick_in = tick_inc[rlcs_pkg::TICK_W-1:0];
                        if (tick_inc >= {1'b0, wait_top_ff}) begin
                           tick_in  = '0;
                           phase_in = rlcs_pkg::PH_IDLE;
                        end
                     end
                  end
                  rlcs_pkg::OP_SET: begin
                     if (idx_ok) begin
                        mem_we    = 1'b1;
                        mem_waddr = item_ff.pixel_index[PIX_W-1:0];
                        mem_wdata = new_pixel;
                     end else begin
                        rsp_data_in.refused = 1'b1;
                     end
                  end
                  rlcs_pkg::OP_START: begin
                     if (phase_ff == rlcs_pkg::PH_IDLE) begin
                        phase_in               = rlcs_pkg::PH_SEND;
                        tick_in                = '0;
                        bp_in                  = '0;
                        pix_in                 = '0;
                        bit_in                 = rlcs_pkg::TOP_BIT;
                        rsp_data_in.line_level = 1'b0;
                     end else begin
                        rsp_data_in.refused = 1'b1;
                     end
                  end
                  default: begin
                     // unused op code: no change
                  end
               endcase
               rsp_data_in.ready_res = (phase_in == rlcs_pkg::PH_IDLE);
            end
         end
         default: begin
            ctrl_in = rlcs_pkg::CT_CLEAR;
         end
      endcase
   end

   // Checks
   `RLCS_ASSERT_NEXT(a_accept_exec, clock, reset, do_accept, ctrl_ff == rlcs_pkg::CT_EXEC)
   `RLCS_ASSERT_NEXT(a_stall_holds, clock, reset,
      ctrl_ff == rlcs_pkg::CT_EXEC && rsp_valid_ff && !rsp_ready,
      ctrl_ff == rlcs_pkg::CT_EXEC && rsp_valid_ff)
   `RLCS_ASSERT_NOW(a_write_source, clock, reset, mem_we,
      ctrl_ff == rlcs_pkg::CT_CLEAR
      || (ctrl_ff == rlcs_pkg::CT_EXEC && item_ff.op == rlcs_pkg::OP_SET))
   `RLCS_ASSERT_NOW(a_slot_range, clock, reset, phase_ff == rlcs_pkg::PH_SEND,
      ({1'b0, bp_ff} < SLOTS_L) && (bit_ff <= rlcs_pkg::TOP_BIT))

endmodule
